@@ hw/rtl/tbs_pkg.sv @@
// Shared types and constants of the text byte sanitizer.
package tbs_pkg;

    localparam int CNT_W     = 13;
    localparam int CHAR_W    = 7;
    localparam int BURST_MAX = 3;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = 13'd512;
    localparam logic [1:0]        MAX_BREAKS  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_LF       = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB      = 7'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 7'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE    = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 7'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       pending_breaks;
        logic             pending_blank;
        logic             after_carriage_return;
        logic [CNT_W-1:0] emitted_count;
    } text_state_t;

    typedef struct packed {
        logic [1:0]                     cnt;
        logic [BURST_MAX-1:0][CHAR_W-1:0] chars;
    } burst_t;

endpackage

@@ hw/rtl/text_byte_sanitizer_top.sv @@
// Top level of the text byte sanitizer: input register, text state and output buffer.
//
// The block cleans a raw text stream, one byte per input transfer, into printable
// ASCII with newlines and single spaces. Each input transfer carries in_byte and
// start_of_text; start_of_text clears all running state before its byte is used.
// Each byte yields zero to three output transfers (pending newlines, a pending
// space, then the character); last_of_run marks the final one of a byte.
// The character limit max_out_chars is written through cfg_we and cfg_wdata, and
// resets to 512. The user must write it only while the block is idle; the block
// itself does not enforce this. An accepted byte sits in the input register, and
// its characters then move into the output buffer, from which the first is offered.
// Throughput is one byte per cycle as long as each byte yields at most one
// character and the receiver takes each one; a byte that yields several characters
// holds the output buffer until all are taken, and the next byte that yields
// characters waits until the buffer drains. Bytes that yield nothing pass
// through even while the buffer is full. When the receiver stalls, the buffer and
// then the input register fill, and in_ready falls. Reset empties both registers,
// clears the text state and restores the limit.
module text_byte_sanitizer_top
    import tbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    logic             in_vld_reg;
    in_item_t         in_item_reg;
    text_state_t      state_reg;
    text_state_t      state_next;
    logic [CNT_W-1:0] max_reg;
    burst_t           burst;
    logic             buf_free;
    logic             advance;
    logic             load;

    // The held byte moves on when it produces nothing or the buffer can take its burst.
    assign advance  = in_vld_reg && ((burst.cnt == 2'd0) || buf_free);
    assign load     = advance && (burst.cnt != 2'd0);
    assign in_ready = !in_vld_reg || advance;

    tbs_step u_step (
        .item          (in_item_reg),
        .state         (state_reg),
        .max_out_chars (max_reg),
        .state_next    (state_next),
        .burst         (burst)
    );

    tbs_burst_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .burst     (burst),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
            max_reg    <= LIMIT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    // The payload register needs no reset; it is qualified by in_vld_reg.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

endmodule

@@ hw/rtl/tbs_step.sv @@
// Per-byte cleaning rule: next text state and the burst of characters one byte produces.
module tbs_step
    import tbs_pkg::*;
(
    input  in_item_t         item,
    input  text_state_t      state,
    input  logic [CNT_W-1:0] max_out_chars,
    output text_state_t      state_next,
    output burst_t           burst
);

    text_state_t       st0;
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  room;
    logic [1:0]        nb;
    logic [1:0]        eb;
    logic              be;
    logic              ce;
    logic [1:0]        used;
    logic              is_printable;

    always_comb
    begin
        st0          = item.start_of_text ? '0 : state;
        state_next   = st0;
        burst.cnt    = 2'd0;
        burst.chars  = '0;
        ch           = item.in_byte[7] ? CH_QUESTION : item.in_byte[6:0];
        room         = max_out_chars - st0.emitted_count;
        nb           = (st0.emitted_count != '0) ? st0.pending_breaks : 2'd0;
        eb           = (room < {{(CNT_W-2){1'b0}}, nb}) ? room[1:0] : nb;
        be           = (st0.emitted_count != '0) && st0.pending_blank && (eb == nb)
                       && (room > {{(CNT_W-2){1'b0}}, eb});
        used         = eb + {1'b0, be};
        ce           = room > {{(CNT_W-2){1'b0}}, used};
        is_printable = (ch > CH_SPACE) && (ch <= CH_TILDE);

        if (st0.emitted_count < max_out_chars)
        begin
            state_next.after_carriage_return = 1'b0;
            if (item.in_byte[7:6] == 2'b10)
            begin
                // Continuation byte of a multi-byte sequence: dropped.
            end
            else if (ch == CH_LF && st0.after_carriage_return)
            begin
                // LF of a CRLF pair: already counted.
            end
            else if (ch == CH_CR || ch == CH_LF)
            begin
                if (st0.pending_breaks < MAX_BREAKS)
                begin
                    state_next.pending_breaks = st0.pending_breaks + 2'd1;
                end
                state_next.pending_blank         = 1'b0;
                state_next.after_carriage_return = (ch == CH_CR);
            end
            else if (ch == CH_TAB || ch == CH_SPACE)
            begin
                if (st0.pending_breaks == 2'd0)
                begin
                    state_next.pending_blank = 1'b1;
                end
            end
            else if (is_printable)
            begin
                burst.cnt = used + {1'b0, ce};
                for (int p = 0; p < BURST_MAX; p++)
                begin
                    if (p < int'(eb))
                    begin
                        burst.chars[p] = CH_LF;
                    end
                    else if (p == int'(eb) && be)
                    begin
                        burst.chars[p] = CH_SPACE;
                    end
                    else
                    begin
                        burst.chars[p] = ch;
                    end
                end
                state_next.emitted_count  = st0.emitted_count
                                            + {{(CNT_W-2){1'b0}}, burst.cnt};
                state_next.pending_breaks = 2'd0;
                state_next.pending_blank  = 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/tbs_burst_buf.sv @@
// Output buffer that holds the burst of one byte and hands it out one character per transfer.
module tbs_burst_buf
    import tbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  burst_t    burst,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [1:0]                       cnt_reg;
    logic [1:0]                       cnt_next;
    logic [BURST_MAX-1:0][CHAR_W-1:0] chars_reg;
    logic [BURST_MAX-1:0][CHAR_W-1:0] chars_next;
    logic                             take;

    assign out_valid            = (cnt_reg != 2'd0);
    assign take                 = out_valid && out_ready;
    assign free                 = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_data.out_char    = chars_reg[0];
    assign out_data.last_of_run = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next   = cnt_reg;
        chars_next = chars_reg;
        if (load)
        begin
            cnt_next   = burst.cnt;
            chars_next = burst.chars;
        end
        else if (take)
        begin
            cnt_next   = cnt_reg - 2'd1;
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                chars_next[i] = chars_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

endmodule

@@ hw/rtl/tbs_checker.sv @@
// Port-level checker of the text byte sanitizer and its binding to the top level.
module tbs_checker
    import tbs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled output transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

    // A stalled output transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

    // Every character is a newline or printable ASCII.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_char == CH_LF) ||
                      ((out_data.out_char >= CH_SPACE) && (out_data.out_char <= CH_TILDE)))
    else $error("output character outside the cleaned set");

    // A burst is held whole, so its next character follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("gap inside a burst");

endmodule

bind text_byte_sanitizer_top tbs_checker u_tbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
